[src/stuffed_command_frame_builder_macros.svh]
`ifndef STUFFED_COMMAND_FRAME_BUILDER_MACROS_SVH
`define STUFFED_COMMAND_FRAME_BUILDER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SCFB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scfb assertion failed");

// next-cycle implication, disabled while in reset
`define SCFB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scfb assertion failed");

`endif

[src/scfb_pkg.sv]
package scfb_pkg;

  localparam int BODY_LEN   = 14;
  localparam int BODY_IDX_W = $clog2(BODY_LEN);
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FLAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE = 2'd1;

  localparam logic [7:0] FLAG_RESET   = 8'd126;
  localparam logic [7:0] ESCAPE_RESET = 8'd125;

  typedef struct packed {
    logic [7:0]         command_code;
    logic [7:0]         motor_index;
    logic signed [31:0] motor_speed;
    logic [7:0]         relay_index;
    logic [7:0]         relay_state;
    logic [7:0]         switch_index;
    logic [7:0]         switch_state;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_t;

  // body[i] is the i-th body byte on the wire
  typedef struct packed {
    logic [BODY_LEN-1:0][7:0] body;
    logic [BODY_LEN-1:0]      esc_mask;
  } frame_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

[src/stuffed_command_frame_builder.sv]
// a transferred command is written into the frame queue, then the back end registers the frame's first byte
// throughput: one output byte per cycle while out_stall is low; a frame is 16 to 30 bytes by escape count
// the byte sequencer in the back end sets the rate; a frame queue decouples the input
// reset: synchronous active-low rst_n clears frame id to 0, empties the queue,
// drops out_valid and loads flag 0x7e and escape 0x7d
`include "stuffed_command_frame_builder_macros.svh"

module stuffed_command_frame_builder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  scfb_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output scfb_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [scfb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                         cfg_data
);
  import scfb_pkg::*;

  logic [7:0] flag_r, flag_nxt;
  logic [7:0] escape_r, escape_nxt;
  logic       push, pop;
  frame_t     push_data, head;
  q_stat_t    q_stat;

  assign cfg_ready = 1'b1;

  always_comb begin
    flag_nxt   = flag_r;
    escape_nxt = escape_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FLAG:   flag_nxt   = cfg_data;
        CFG_ESCAPE: escape_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= FLAG_RESET;
      escape_r <= ESCAPE_RESET;
    end else begin
      flag_r   <= flag_nxt;
      escape_r <= escape_nxt;
    end
  end

  scfb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .flag_val   (flag_r),
    .escape_val (escape_r),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  scfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  scfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .flag_val   (flag_r),
    .escape_val (escape_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  `SCFB_ASSERT_NOW(a_end_is_flag, clk, rst_n, out_valid && out_data.frame_end, out_data.out_byte == flag_r)
  `SCFB_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, push, !q_stat.empty)
  `SCFB_ASSERT_NEXT(a_pop_closes_frame, clk, rst_n, pop, out_valid && out_data.frame_end)

endmodule

[src/scfb_front.sv]
module scfb_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  scfb_pkg::in_t   in_data,
  input  logic [7:0]      flag_val,
  input  logic [7:0]      escape_val,
  input  scfb_pkg::q_stat_t q_stat,
  output logic            push,
  output scfb_pkg::frame_t push_data
);
  import scfb_pkg::*;

  logic [31:0] frame_id_r;
  logic [31:0] frame_id_nxt;

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  always_comb begin
    frame_id_nxt = frame_id_r;
    if (push) begin
      frame_id_nxt = frame_id_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_id_r <= 32'd0;
    end else begin
      frame_id_r <= frame_id_nxt;
    end
  end

  // body layout, big-endian words
  always_comb begin
    push_data.body[0]  = frame_id_r[31:24];
    push_data.body[1]  = frame_id_r[23:16];
    push_data.body[2]  = frame_id_r[15:8];
    push_data.body[3]  = frame_id_r[7:0];
    push_data.body[4]  = in_data.command_code;
    push_data.body[5]  = in_data.motor_index;
    push_data.body[6]  = in_data.motor_speed[31:24];
    push_data.body[7]  = in_data.motor_speed[23:16];
    push_data.body[8]  = in_data.motor_speed[15:8];
    push_data.body[9]  = in_data.motor_speed[7:0];
    push_data.body[10] = in_data.relay_index;
    push_data.body[11] = in_data.relay_state;
    push_data.body[12] = in_data.switch_index;
    push_data.body[13] = in_data.switch_state;
    for (int i = 0; i < BODY_LEN; i++) begin
      push_data.esc_mask[i] = (push_data.body[i] == flag_val) ||
                              (push_data.body[i] == escape_val);
    end
  end

endmodule

[src/scfb_queue.sv]
module scfb_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  scfb_pkg::frame_t  push_data,
  input  logic              pop,
  output scfb_pkg::frame_t  head,
  output scfb_pkg::q_stat_t q_stat
);
  import scfb_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign head         = mem_r[rd_ptr_r];
  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[src/scfb_back.sv]
module scfb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  scfb_pkg::frame_t  head,
  input  scfb_pkg::q_stat_t q_stat,
  output logic              pop,
  input  logic [7:0]        flag_val,
  input  logic [7:0]        escape_val,
  output logic              out_valid,
  input  logic              out_stall,
  output scfb_pkg::out_t    out_data
);
  import scfb_pkg::*;

  typedef enum logic [2:0] {
    ST_OPEN  = 3'b001,
    ST_BODY  = 3'b010,
    ST_CLOSE = 3'b100
  } stage_t;

  stage_t                stage_r, stage_nxt;
  logic [BODY_IDX_W-1:0] idx_r, idx_nxt;
  logic                  esc_done_r, esc_done_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;
  logic                  load;

  assign load      = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stage_nxt     = stage_r;
    idx_nxt       = idx_r;
    esc_done_nxt  = esc_done_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = 1'b0;
      if (!q_stat.empty) begin
        out_valid_nxt = 1'b1;
        case (stage_r)
          ST_OPEN: begin
            out_data_nxt = '{out_byte: flag_val, frame_end: 1'b0};
            stage_nxt    = ST_BODY;
            idx_nxt      = '0;
            esc_done_nxt = 1'b0;
          end
          ST_BODY: begin
            if (head.esc_mask[idx_r] && !esc_done_r) begin
              out_data_nxt = '{out_byte: escape_val, frame_end: 1'b0};
              esc_done_nxt = 1'b1;
            end else begin
              out_data_nxt = '{out_byte: head.body[idx_r], frame_end: 1'b0};
              esc_done_nxt = 1'b0;
              if (idx_r == BODY_IDX_W'(BODY_LEN - 1)) begin
                stage_nxt = ST_CLOSE;
              end else begin
                idx_nxt = idx_r + BODY_IDX_W'(1);
              end
            end
          end
          ST_CLOSE: begin
            out_data_nxt = '{out_byte: flag_val, frame_end: 1'b1};
            stage_nxt    = ST_OPEN;
            pop          = 1'b1;
          end
          default: begin
            out_valid_nxt = 1'b0;
            stage_nxt     = ST_OPEN;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r     <= ST_OPEN;
      idx_r       <= '0;
      esc_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stage_r     <= stage_nxt;
      idx_r       <= idx_nxt;
      esc_done_r  <= esc_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

[dv/tb_stuffed_command_frame_builder.sv]
module tb_stuffed_command_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  import scfb_pkg::*;

  localparam int RAND_PER_PHASE = 70;
  localparam int NUM_PHASES     = 6;
  localparam int QUIET_LIMIT    = 2000;
  localparam int TAIL_CYCLES    = 8;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    in_t        cmd;
    logic [7:0] typed_len;
  } cmd_row_t;

  // typed_len of 0 leaves the row to the predictor alone
  localparam cmd_row_t DIRECTED_ROWS [14] = '{
    '{in_t'{8'h00, 8'h00, 32'sh00000000, 8'h00, 8'h00, 8'h00, 8'h00}, 8'd16},
    '{in_t'{8'hff, 8'hff, -32'sd1,       8'hff, 8'hff, 8'hff, 8'hff}, 8'd16},
    '{in_t'{8'h7e, 8'h7e, 32'sh7e7e7e7e, 8'h7e, 8'h7e, 8'h7e, 8'h7e}, 8'd26},
    '{in_t'{8'h7d, 8'h7d, 32'sh7d7d7d7d, 8'h7d, 8'h7d, 8'h7d, 8'h7d}, 8'd26},
    '{in_t'{8'h00, 8'h00, 32'sh80000000, 8'h00, 8'h00, 8'h00, 8'h00}, 8'd16},
    '{in_t'{8'h01, 8'h01, 32'sh7fffffff, 8'h01, 8'h01, 8'h01, 8'h01}, 8'd16},
    '{in_t'{8'haa, 8'h55, 32'shaa55aa55, 8'haa, 8'h55, 8'haa, 8'h55}, 8'd16},
    '{in_t'{8'h55, 8'haa, 32'sh55aa55aa, 8'h55, 8'haa, 8'h55, 8'haa}, 8'd16},
    '{in_t'{8'h7e, 8'h7d, 32'sh7e7d0102, 8'h7e, 8'h00, 8'h7d, 8'h00}, 8'd0},
    '{in_t'{8'h7d, 8'h7e, 32'sh00007e7d, 8'h10, 8'h20, 8'h7e, 8'h7d}, 8'd0},
    '{in_t'{8'h80, 8'h01, 32'sh01020408, 8'h40, 8'h20, 8'h10, 8'h08}, 8'd16},
    '{in_t'{8'h7f, 8'hfe, 32'sh7c7f7e00, 8'h7c, 8'h7f, 8'hfd, 8'hfe}, 8'd0},
    '{in_t'{8'h03, 8'h07, -32'sd126,     8'h0f, 8'h1f, 8'h3f, 8'h7e}, 8'd0},
    '{in_t'{8'hc0, 8'he0, 32'shf0f8fcfe, 8'hc0, 8'he0, 8'hf0, 8'hf8}, 8'd16}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  stuffed_command_frame_builder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [31:0] frame_id  = '0;
  logic [7:0]  flag_byte = FLAG_RESET;
  logic [7:0]  esc_byte  = ESCAPE_RESET;

  out_t       pending_bytes [$];
  logic [7:0] typed_len_q [$];

  int err_count    = 0;
  int n_cmds       = 0;
  int n_bytes      = 0;
  int n_escapes    = 0;
  int n_reg_writes = 0;
  int quiet_cycles = 0;
  bit no_idle      = 1'b0;

  out_t       exp_byte;
  int         frame_len;
  logic [7:0] typed;

  function automatic int stuff_frame(input in_t cmd);
    logic [7:0]  body [BODY_LEN];
    logic [31:0] speed_bits;
    int          len;
    speed_bits = cmd.motor_speed;
    body[0]  = frame_id[31:24];
    body[1]  = frame_id[23:16];
    body[2]  = frame_id[15:8];
    body[3]  = frame_id[7:0];
    body[4]  = cmd.command_code;
    body[5]  = cmd.motor_index;
    body[6]  = speed_bits[31:24];
    body[7]  = speed_bits[23:16];
    body[8]  = speed_bits[15:8];
    body[9]  = speed_bits[7:0];
    body[10] = cmd.relay_index;
    body[11] = cmd.relay_state;
    body[12] = cmd.switch_index;
    body[13] = cmd.switch_state;
    pending_bytes.push_back(out_t'{flag_byte, 1'b0});
    len = 2;
    for (int i = 0; i < BODY_LEN; i++) begin
      if (body[i] == flag_byte || body[i] == esc_byte) begin
        pending_bytes.push_back(out_t'{esc_byte, 1'b0});
        len++;
        n_escapes++;
      end
      pending_bytes.push_back(out_t'{body[i], 1'b0});
      len++;
    end
    pending_bytes.push_back(out_t'{flag_byte, 1'b1});
    frame_id = frame_id + 32'd1;
    return len;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_bytes++;
        if (pending_bytes.size() == 0) begin
          $error("unexpected byte transfer: out_byte %02h frame_end %0b",
                 out_data.out_byte, out_data.frame_end);
          err_count++;
        end else begin
          exp_byte = pending_bytes.pop_front();
          if (out_data.out_byte !== exp_byte.out_byte) begin
            $error("out_byte mismatch: expected %02h, actual %02h",
                   exp_byte.out_byte, out_data.out_byte);
            err_count++;
          end
          if (out_data.frame_end !== exp_byte.frame_end) begin
            $error("frame_end mismatch: expected %0b, actual %0b",
                   exp_byte.frame_end, out_data.frame_end);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_cmds++;
        frame_len = stuff_frame(in_data);
        typed = (typed_len_q.size() != 0) ? typed_len_q.pop_front() : 8'd0;
        if (typed != 8'd0 && int'(typed) != frame_len) begin
          $error("frame length mismatch: expected %0d, actual %0d", typed, frame_len);
          err_count++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        n_reg_writes++;
        case (cfg_index)
          CFG_FLAG:   flag_byte = cfg_data;
          CFG_ESCAPE: esc_byte  = cfg_data;
          default:    ;
        endcase
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver back-pressure
  initial begin
    int   stall_hold;
    logic stall_val;
    stall_hold = 0;
    stall_val  = 1'b0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold == 0) begin
        if (no_idle || $urandom_range(0, 9) < 7) begin
          stall_val  = 1'b0;
          stall_hold = $urandom_range(1, 8);
        end else begin
          stall_val  = 1'b1;
          stall_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
        end
      end
      stall_hold--;
      out_stall <= stall_val && !no_idle;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // body bytes lean toward the current flag and escape values
  function automatic logic [7:0] rand_field_byte();
    case ($urandom_range(0, 9))
      0, 1:    return flag_byte;
      2, 3:    return esc_byte;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_t rand_cmd();
    in_t c;
    c.command_code = rand_field_byte();
    c.motor_index  = rand_field_byte();
    if ($urandom_range(0, 3) == 0)
      c.motor_speed = $urandom();
    else
      c.motor_speed = {rand_field_byte(), rand_field_byte(),
                       rand_field_byte(), rand_field_byte()};
    c.relay_index  = rand_field_byte();
    c.relay_state  = rand_field_byte();
    c.switch_index = rand_field_byte();
    c.switch_state = rand_field_byte();
    return c;
  endfunction

  task automatic send_cmd(input in_t cmd, input logic [7:0] typed_len);
    int gap;
    typed_len_q.push_back(typed_len);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk); while (in_stall);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_FLAG;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      send_cmd(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].typed_len);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      no_idle = (p == 4);
      case (p)
        0: begin
          // flag equal to escape
          write_reg(CFG_FLAG, 8'h00);
          write_reg(CFG_ESCAPE, 8'h00);
        end
        1: begin
          write_reg(CFG_FLAG, 8'h00);
          write_reg(CFG_ESCAPE, 8'hff);
        end
        2: begin
          write_reg(CFG_FLAG, 8'hff);
          write_reg(CFG_ESCAPE, 8'h00);
        end
        3: begin
          write_reg(CFG_FLAG, 8'($urandom_range(0, 255)));
          write_reg(CFG_ESCAPE, 8'($urandom_range(0, 255)));
          write_reg(CFG_SPARE_A, 8'($urandom_range(0, 255)));
          write_reg(CFG_SPARE_B, 8'($urandom_range(0, 255)));
        end
        4: begin
          // frame id bytes run into both values during this phase
          write_reg(CFG_FLAG, 8'(frame_id[7:0] + $urandom_range(1, 20)));
          write_reg(CFG_ESCAPE, frame_id[15:8]);
        end
        default: begin
          write_reg(CFG_FLAG, FLAG_RESET);
          write_reg(CFG_ESCAPE, ESCAPE_RESET);
        end
      endcase
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        if (p == NUM_PHASES - 1 && k == RAND_PER_PHASE / 2)
          wait_drained();
        send_cmd(rand_cmd(), 8'd0);
      end
    end
    wait_drained();

    $display("summary: %0d commands framed, %0d bytes checked, %0d body bytes escaped",
             n_cmds, n_bytes, n_escapes);
    $display("summary: %0d register transfers, flag equal to escape, 00/ff extremes, spare indexes",
             n_reg_writes);
    if (pending_bytes.size() != 0) begin
      $error("%0d expected bytes never arrived", pending_bytes.size());
      err_count++;
    end
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
